[rtl/core/jsu_pkg.sv]
`timescale 1ns / 1ps
package jsu_pkg;

  localparam int JSU_QDEPTH = 2;
  localparam int RUN_MAX    = 4;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_INVALID = 2'd1;
  localparam logic [1:0] ERR_EOF     = 2'd2;

  localparam logic [7:0] CHR_QUOTE  = 8'h22;
  localparam logic [7:0] CHR_BSLASH = 8'h5C;
  localparam logic [7:0] CHR_SLASH  = 8'h2F;
  localparam logic [7:0] CHR_B      = 8'h62;
  localparam logic [7:0] CHR_F      = 8'h66;
  localparam logic [7:0] CHR_N      = 8'h6E;
  localparam logic [7:0] CHR_R      = 8'h72;
  localparam logic [7:0] CHR_T      = 8'h74;
  localparam logic [7:0] CHR_U      = 8'h75;
  localparam logic [7:0] CTRL_LIM   = 8'h20;

  localparam logic [15:0] SUR_HI_MIN = 16'hD800;
  localparam logic [15:0] SUR_HI_MAX = 16'hDBFF;
  localparam logic [15:0] SUR_LO_MIN = 16'hDC00;
  localparam logic [15:0] SUR_LO_MAX = 16'hDFFF;
  localparam logic [20:0] CP_SUPP    = 21'h10000;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] code;
  } res_t;

  // one input word's worth of results, cnt is 1..4
  typedef struct packed {
    logic [2:0]           cnt;
    res_t [RUN_MAX-1:0]   ent;
  } run_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // {ok, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic run_t utf8_enc(input logic [20:0] cp);
    run_t r;
    r = '0;
    if (cp < 21'h80) begin
      r.cnt = 3'd1;
      r.ent[0].data = cp[7:0];
    end else if (cp < 21'h800) begin
      r.cnt = 3'd2;
      r.ent[0].data = {3'b110, cp[10:6]};
      r.ent[1].data = {2'b10, cp[5:0]};
    end else if (cp < CP_SUPP) begin
      r.cnt = 3'd3;
      r.ent[0].data = {4'b1110, cp[15:12]};
      r.ent[1].data = {2'b10, cp[11:6]};
      r.ent[2].data = {2'b10, cp[5:0]};
    end else begin
      r.cnt = 3'd4;
      r.ent[0].data = {5'b11110, cp[20:18]};
      r.ent[1].data = {2'b10, cp[17:12]};
      r.ent[2].data = {2'b10, cp[11:6]};
      r.ent[3].data = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

[rtl/core/jsu_front.sv]
`timescale 1ns / 1ps
module jsu_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  jsu_pkg::q_stat_t q_stat,
  output logic            push,
  output jsu_pkg::run_t   push_run
);

  typedef enum logic [6:0] {
    PH_OPEN    = 7'b0000001,
    PH_BODY    = 7'b0000010,
    PH_ESC     = 7'b0000100,
    PH_HEX     = 7'b0001000,
    PH_AHIGH   = 7'b0010000,
    PH_AHIGH_BS = 7'b0100000,
    PH_LOW_HEX = 7'b1000000
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] hex_accum, hex_accum_next;
  logic [15:0] high_half, high_half_next;
  logic [1:0]  digit_count, digit_count_next;

  logic          in_fire;
  logic [4:0]    hv;
  logic [15:0]   acc_dig;
  logic          last_digit;
  logic [20:0]   cp_sel;
  jsu_pkg::run_t u8;

  logic          body_has;
  jsu_pkg::res_t body_ent;
  phase_t        body_ph;
  logic          esc_u;
  logic          esc_bad;
  logic [7:0]    esc_chr;

  jsu_pkg::run_t run_c;
  logic          push_c;

  assign in_ready = !q_stat.full;
  assign in_fire  = in_valid && in_ready;

  assign hv         = jsu_pkg::hex_digit(in_byte);
  assign acc_dig    = {hex_accum[11:0], hv[3:0]};
  assign last_digit = (digit_count == 2'd3);

  always_comb begin
    if (phase == PH_HEX) begin
      cp_sel = {5'd0, acc_dig};
    end else if (phase == PH_LOW_HEX) begin
      cp_sel = jsu_pkg::CP_SUPP + {1'b0, high_half[9:0], acc_dig[9:0]};
    end else begin
      cp_sel = {5'd0, high_half};
    end
  end

  assign u8 = jsu_pkg::utf8_enc(cp_sel);

  always_comb begin
    body_has = 1'b1;
    body_ent = '0;
    body_ph  = PH_OPEN;
    if (in_byte == 8'd0) begin
      body_ent.kind = jsu_pkg::KIND_ERR;
      body_ent.code = jsu_pkg::ERR_EOF;
    end else if (in_byte == jsu_pkg::CHR_QUOTE) begin
      body_ent.kind = jsu_pkg::KIND_DONE;
    end else if (in_byte == jsu_pkg::CHR_BSLASH) begin
      body_has = 1'b0;
      body_ph  = PH_ESC;
    end else if (in_byte < jsu_pkg::CTRL_LIM) begin
      body_ent.kind = jsu_pkg::KIND_ERR;
      body_ent.code = jsu_pkg::ERR_INVALID;
    end else begin
      body_ent.data = in_byte;
      body_ph       = PH_BODY;
    end
  end

  always_comb begin
    esc_u   = 1'b0;
    esc_bad = 1'b0;
    esc_chr = in_byte;
    unique case (in_byte)
      jsu_pkg::CHR_QUOTE,
      jsu_pkg::CHR_BSLASH,
      jsu_pkg::CHR_SLASH:  esc_chr = in_byte;
      jsu_pkg::CHR_B:      esc_chr = 8'h08;
      jsu_pkg::CHR_F:      esc_chr = 8'h0C;
      jsu_pkg::CHR_N:      esc_chr = 8'h0A;
      jsu_pkg::CHR_R:      esc_chr = 8'h0D;
      jsu_pkg::CHR_T:      esc_chr = 8'h09;
      jsu_pkg::CHR_U:      esc_u   = 1'b1;
      default:             esc_bad = 1'b1;
    endcase
  end

  always_comb begin
    run_c            = '0;
    push_c           = 1'b0;
    phase_next       = phase;
    hex_accum_next   = hex_accum;
    high_half_next   = high_half;
    digit_count_next = digit_count;
    unique case (phase)
      PH_OPEN: begin
        if (in_byte == jsu_pkg::CHR_QUOTE) begin
          phase_next = PH_BODY;
        end else begin
          push_c = 1'b1;
          run_c.cnt = 3'd1;
          run_c.ent[0].kind = jsu_pkg::KIND_ERR;
          run_c.ent[0].code = jsu_pkg::ERR_INVALID;
          phase_next = PH_OPEN;
        end
      end
      PH_BODY: begin
        push_c       = body_has;
        run_c.cnt    = 3'd1;
        run_c.ent[0] = body_ent;
        phase_next   = body_ph;
      end
      PH_ESC: begin
        if (esc_u) begin
          hex_accum_next   = 16'd0;
          digit_count_next = 2'd0;
          phase_next       = PH_HEX;
        end else if (esc_bad) begin
          push_c = 1'b1;
          run_c.cnt = 3'd1;
          run_c.ent[0].kind = jsu_pkg::KIND_ERR;
          run_c.ent[0].code = jsu_pkg::ERR_INVALID;
          phase_next = PH_OPEN;
        end else begin
          push_c = 1'b1;
          run_c.cnt = 3'd1;
          run_c.ent[0].data = esc_chr;
          phase_next = PH_BODY;
        end
      end
      PH_HEX, PH_LOW_HEX: begin
        if (!hv[4]) begin
          push_c = 1'b1;
          run_c.cnt = 3'd1;
          run_c.ent[0].kind = jsu_pkg::KIND_ERR;
          run_c.ent[0].code = jsu_pkg::ERR_INVALID;
          phase_next = PH_OPEN;
        end else begin
          hex_accum_next = acc_dig;
          if (!last_digit) begin
            digit_count_next = digit_count + 2'd1;
          end else begin
            digit_count_next = 2'd0;
            if (phase == PH_HEX) begin
              if (acc_dig >= jsu_pkg::SUR_HI_MIN && acc_dig <= jsu_pkg::SUR_HI_MAX) begin
                high_half_next = acc_dig;
                phase_next     = PH_AHIGH;
              end else begin
                push_c     = 1'b1;
                run_c      = u8;
                phase_next = PH_BODY;
              end
            end else if (acc_dig < jsu_pkg::SUR_LO_MIN || acc_dig > jsu_pkg::SUR_LO_MAX) begin
              push_c = 1'b1;
              run_c.cnt = 3'd1;
              run_c.ent[0].kind = jsu_pkg::KIND_ERR;
              run_c.ent[0].code = jsu_pkg::ERR_INVALID;
              phase_next = PH_OPEN;
            end else begin
              push_c     = 1'b1;
              run_c      = u8;
              phase_next = PH_BODY;
            end
          end
        end
      end
      PH_AHIGH: begin
        if (in_byte == jsu_pkg::CHR_BSLASH) begin
          phase_next = PH_AHIGH_BS;
        end else begin
          // lone high surrogate: three bytes, then the word as a body byte
          push_c     = 1'b1;
          run_c      = u8;
          phase_next = body_ph;
          if (body_has) begin
            run_c.cnt    = 3'd4;
            run_c.ent[3] = body_ent;
          end
        end
      end
      PH_AHIGH_BS: begin
        if (esc_u) begin
          hex_accum_next   = 16'd0;
          digit_count_next = 2'd0;
          phase_next       = PH_LOW_HEX;
        end else begin
          push_c    = 1'b1;
          run_c     = u8;
          run_c.cnt = 3'd4;
          if (esc_bad) begin
            run_c.ent[3].kind = jsu_pkg::KIND_ERR;
            run_c.ent[3].code = jsu_pkg::ERR_INVALID;
            phase_next = PH_OPEN;
          end else begin
            run_c.ent[3].data = esc_chr;
            phase_next = PH_BODY;
          end
        end
      end
      default: begin
        phase_next = PH_OPEN;
      end
    endcase
  end

  assign push     = in_fire && push_c;
  assign push_run = run_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_OPEN;
      hex_accum   <= 16'd0;
      high_half   <= 16'd0;
      digit_count <= 2'd0;
    end else if (in_fire) begin
      phase       <= phase_next;
      hex_accum   <= hex_accum_next;
      high_half   <= high_half_next;
      digit_count <= digit_count_next;
    end
  end

endmodule

[rtl/core/jsu_queue.sv]
`timescale 1ns / 1ps
module jsu_queue #(
  parameter int DEPTH = jsu_pkg::JSU_QDEPTH,
  parameter int WIDTH = $bits(jsu_pkg::run_t)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output jsu_pkg::q_stat_t stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             push_ok, pop_ok;

  assign stat.full  = (count == CW'(DEPTH));
  assign stat.empty = (count == '0);
  assign push_ok    = push && !stat.full;
  assign pop_ok     = pop && !stat.empty;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      count <= count + CW'(push_ok) - CW'(pop_ok);
    end
  end

endmodule

[rtl/core/jsu_back.sv]
`timescale 1ns / 1ps
module jsu_back (
  input  logic             clk,
  input  logic             rst,
  input  jsu_pkg::run_t    head,
  input  jsu_pkg::q_stat_t q_stat,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_byte,
  output logic [1:0]       error_code,
  output logic             last_of_run
);

  logic [1:0]    idx;
  logic          load, take, end_of_run;
  jsu_pkg::res_t cur;

  assign load       = !out_valid || out_ready;
  assign take       = load && !q_stat.empty;
  assign cur        = head.ent[idx];
  assign end_of_run = ({1'b0, idx} == head.cnt - 3'd1);
  assign pop        = take && end_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= !q_stat.empty;
      end
      if (take) begin
        idx <= end_of_run ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_kind    <= cur.kind;
      out_byte    <= cur.data;
      error_code  <= cur.code;
      last_of_run <= end_of_run;
    end
  end

endmodule

[rtl/core/json_string_unescape_utf8.sv]
`timescale 1ns / 1ps
// The first result of an accepted word is written to the run queue, then registered at the output.
// Throughput: one input word per cycle; a word giving k results is emitted one result
// at a time, and input stalls only when the run queue (QDEPTH runs) is full.
// Reset (rst, synchronous): parser back to awaiting the opening quote,
// run queue emptied, out_valid dropped.
module json_string_unescape_utf8 #(
  parameter int QDEPTH = jsu_pkg::JSU_QDEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic [1:0] error_code,
  output logic       last_of_run
);

  jsu_pkg::q_stat_t q_stat;
  jsu_pkg::run_t    push_run, head;
  logic             push, pop;

  jsu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_stat   (q_stat),
    .push     (push),
    .push_run (push_run)
  );

  jsu_queue #(
    .DEPTH (QDEPTH),
    .WIDTH ($bits(jsu_pkg::run_t))
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_run),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  jsu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_byte    (out_byte),
    .error_code  (error_code),
    .last_of_run (last_of_run)
  );

endmodule

[rtl/core/jsu_checker.sv]
`timescale 1ns / 1ps
module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte,
  input logic [1:0] error_code,
  input logic       last_of_run
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte)
      && $stable(error_code) && $stable(last_of_run))
    else $error("stalled output word changed");

  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != jsu_pkg::KIND_DATA |-> out_byte == 8'd0 && last_of_run)
    else $error("close or error word carries data or is not last");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_kind == jsu_pkg::KIND_ERR) == (error_code != jsu_pkg::ERR_NONE)))
    else $error("error code does not match kind");

endmodule

bind json_string_unescape_utf8 jsu_checker u_chk (.*);
